// File: sv/pll_pkg.sv
// Shared types and constants for the positional linked list engine.
// No dependencies; every other file but pll_fifo imports this package.
`timescale 1ns / 1ps

package pll_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      list_count;
  } out_word_t;

  // Decoded request as it sits in the command queue
  typedef struct packed {
    op_e                     op;
    logic                    pos_zero;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        hops;      // links to follow from the head
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: sv/pll_fifo.sv
// Small register-based FIFO with push/full and pop/empty sides.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps

module pll_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == NW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/pll_front.sv
// Front end: decodes request words and queues them as commands.
// Depends on pll_pkg and pll_fifo.
`timescale 1ns / 1ps

module pll_front import pll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t in_word_i,
  output logic     full_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o,
  output logic     cmd_empty_o
);

  cmd_t dec_cmd;

  always_comb begin
    dec_cmd.position = in_word_i.position;
    dec_cmd.value    = in_word_i.value;
    dec_cmd.pos_zero = (in_word_i.position == '0);
    case (in_word_i.kind)
      KIND_INSERT: dec_cmd.op = OP_INSERT;
      KIND_DELETE: dec_cmd.op = OP_DELETE;
      KIND_READ:   dec_cmd.op = OP_READ;
      default:     dec_cmd.op = OP_NOP;
    endcase
    // read, and any request at position 0, lands on the node itself; insert/delete on its predecessor
    if (dec_cmd.op == OP_READ || dec_cmd.pos_zero) begin
      dec_cmd.hops = in_word_i.position;
    end else begin
      dec_cmd.hops = in_word_i.position - 1'b1;
    end
  end

  pll_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (dec_cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// File: sv/pll_back.sv
// Back end: node pool, link walk and free-node stack; runs one command at a time.
// Depends on pll_pkg.
`timescale 1ns / 1ps

module pll_back import pll_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_word_t res_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ALLOC  = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_FIX    = 7'b0001000,
    S_UNLINK = 7'b0010000,
    S_SPLICE = 7'b0100000,
    S_DONE   = 7'b1000000
  } back_state_e;

  // node pool and free stack
  logic signed [DATA_WIDTH-1:0] value_mem [CAPACITY];
  logic [IW-1:0]                link_mem  [CAPACITY];
  logic [IW-1:0]                free_mem  [CAPACITY];

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  status_e     status_q, status_d;
  logic signed [VAL_W-1:0] rdata_q, rdata_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] free_top_q, free_top_d;
  logic [POS_W-1:0] remain_q, remain_d;
  logic          first_q, first_d;
  logic [IW-1:0] target_q, target_d;
  logic [IW-1:0] node_q, node_d;
  logic [IW-1:0] victim_q, victim_d;

  logic signed [DATA_WIDTH-1:0] value_rd_q;
  logic [IW-1:0] link_rd_q;
  logic [IW-1:0] free_rd_q;

  logic [IW-1:0] cur;
  logic [IW-1:0] link_raddr;
  logic [IW-1:0] free_raddr;
  logic [CW-1:0] free_top_m1;
  logic          link_we, value_we, free_we;
  logic [IW-1:0] link_waddr, link_wdata, value_waddr, free_wdata;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic [IW-1:0] new_node;

  assign cur         = first_q ? head_q : link_rd_q;
  assign link_raddr  = (state_q == S_FIX) ? link_rd_q : cur;
  assign free_top_m1 = free_top_q - 1'b1;
  assign free_raddr  = free_top_m1[IW-1:0];
  assign pos_ext     = PW'(cmd_i.position);
  assign cnt_ext     = PW'(count_q);
  assign new_node    = (free_top_q != '0) ? free_rd_q : fresh_q[IW-1:0];

  assign res_o = '{status:     status_q,
                   read_value: rdata_q,
                   list_count: COUNT_W'(count_q)};

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    rdata_d    = rdata_q;
    head_d     = head_q;
    count_d    = count_q;
    fresh_d    = fresh_q;
    free_top_d = free_top_q;
    remain_d   = remain_q;
    first_d    = first_q;
    target_d   = target_q;
    node_d     = node_q;
    victim_d   = victim_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    link_we    = 1'b0;
    link_waddr = target_q;
    link_wdata = link_rd_q;
    value_we   = 1'b0;
    value_waddr = new_node;
    free_we    = 1'b0;
    free_wdata = victim_q;

    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          rdata_d   = '0;
          status_d  = ST_BADPOS;
          first_d   = 1'b1;
          remain_d  = cmd_i.hops;
          state_d   = S_DONE;
          case (cmd_i.op)
            OP_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = ST_BADPOS;
              end else if (count_q == CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_ALLOC;
              end
            end
            OP_DELETE, OP_READ: begin
              if (pos_ext < cnt_ext) begin
                state_d = S_WALK;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_ALLOC: begin
        // take a recycled node if there is one, else a never-used one
        node_d      = new_node;
        value_we    = 1'b1;
        value_waddr = new_node;
        if (free_top_q != '0) begin
          free_top_d = free_top_q - 1'b1;
        end else begin
          fresh_d = fresh_q + 1'b1;
        end
        if (cmd_q.pos_zero) begin
          link_we    = 1'b1;
          link_waddr = new_node;
          link_wdata = head_q;
          head_d     = new_node;
          count_d    = count_q + 1'b1;
          status_d   = ST_OK;
          state_d    = S_DONE;
        end else begin
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        // one link per cycle; the read of link[cur] is issued every cycle
        if (remain_q == '0) begin
          target_d = cur;
          state_d  = S_FIX;
        end else begin
          remain_d = remain_q - 1'b1;
          first_d  = 1'b0;
        end
      end

      S_FIX: begin
        case (cmd_q.op)
          OP_INSERT: begin
            link_we    = 1'b1;
            link_waddr = node_q;
            link_wdata = link_rd_q;
            state_d    = S_SPLICE;
          end
          OP_DELETE: begin
            if (cmd_q.pos_zero) begin
              head_d     = (count_q == CW'(1)) ? '0 : link_rd_q;
              free_we    = 1'b1;
              free_wdata = target_q;
              free_top_d = free_top_q + 1'b1;
              count_d    = count_q - 1'b1;
              status_d   = ST_OK;
              state_d    = S_DONE;
            end else begin
              victim_d = link_rd_q;
              state_d  = S_UNLINK;
            end
          end
          OP_READ: begin
            rdata_d  = VAL_W'(value_rd_q);
            status_d = ST_OK;
            state_d  = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end

      S_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = target_q;
        link_wdata = link_rd_q;
        free_we    = 1'b1;
        free_wdata = victim_q;
        free_top_d = free_top_q + 1'b1;
        count_d    = count_q - 1'b1;
        status_d   = ST_OK;
        state_d    = S_DONE;
      end

      S_SPLICE: begin
        link_we    = 1'b1;
        link_waddr = target_q;
        link_wdata = node_q;
        count_d    = count_q + 1'b1;
        status_d   = ST_OK;
        state_d    = S_DONE;
      end

      S_DONE: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      fresh_q    <= '0;
      free_top_q <= '0;
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      fresh_q    <= fresh_d;
      free_top_q <= free_top_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rdata_q  <= rdata_d;
    remain_q <= remain_d;
    first_q  <= first_d;
    target_q <= target_d;
    node_q   <= node_d;
    victim_q <= victim_d;
  end

  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[value_waddr] <= DATA_WIDTH'(cmd_q.value);
    end
    value_rd_q <= value_mem[cur];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_top_q[IW-1:0]] <= free_wdata;
    end
    free_rd_q <= free_mem[free_raddr];
  end

endmodule

// File: sv/positional_linked_list_engine.sv
// Positional linked list engine: an ordered list of signed values kept in a
// fixed pool of CAPACITY nodes joined by next links. Each request word inserts
// a value at a position (0 to count), deletes at a position below count, or
// reads at a position below count, and yields exactly one result word with a
// status (ok, bad position, pool full), the value read (zero unless a read
// succeeds) and the list count afterwards. Both sides look like queues: push
// a word while full is low, pop a result while empty is low. A small command
// queue sits between the decode front and the execution back, and a result
// queue holds finished words, so new requests are taken while results wait.
// The back runs one request at a time and finds a position by following
// links from the head, one node per clock through the link memory's
// registered read port. Rejected requests skip the walk and go straight to
// their result word. Nothing needs clearing after reset: recycled nodes are
// popped from the free stack first, and never-used ones are handed out from
// a counter while the stack is empty, so the block is ready right away.
// Depends on pll_pkg, pll_fifo, pll_front, pll_back.
`timescale 1ns / 1ps

module positional_linked_list_engine import pll_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // request side
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  cmd_t      cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_word_t res_word;

  // decode and queue incoming words
  pll_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_word_i   (in_word_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  // list walk and update; only starts a command when a result slot is free
  pll_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  // finished words wait here until popped
  pll_fifo #(
    .T     (out_word_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_word_o),
    .empty_o (empty)
  );

endmodule

// File: sim/testbench.sv
// Self-checking bench for positional_linked_list_engine: drives request words,
// predicts each result word from a shadow list and checks them in order.
// Depends on pll_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
  import pll_pkg::*;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned IDLE_PCT       = 18;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_word_t  in_word_i = '0;
  logic      full;
  logic      empty;
  out_word_t out_word_o;

  // Shadow of the list contents, head first, and results still owed.
  logic signed [VAL_W-1:0] shadow_list[$];
  out_word_t               pending_results[$];
  out_word_t               next_expected;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned list_target    = 0;
  logic        steady_flow    = 1'b0;  // neither side inserts idle cycles
  logic        rx_stalled     = 1'b0;
  event        stall_kick;

  positional_linked_list_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow list predictor
  // ---------------------------------------------------------------------------
  // Pool is full exactly when the list holds CAPACITY items, since every
  // delete hands its node back. Position is checked before the pool.
  function automatic out_word_t predict_list_op(in_word_t w);
    out_word_t   r;
    int unsigned pos;
    int unsigned size;
    pos          = w.position;
    size         = shadow_list.size();
    r.status     = ST_BADPOS;
    r.read_value = '0;
    case (op_e'(w.kind))
      OP_INSERT: begin
        if (pos <= size) begin
          if (size == CAPACITY_DEF) begin
            r.status = ST_FULL;
          end else begin
            shadow_list.insert(pos, w.value);
            r.status = ST_OK;
          end
        end
      end
      OP_DELETE: begin
        if (pos < size) begin
          shadow_list.delete(pos);
          r.status = ST_OK;
        end
      end
      OP_READ: begin
        if (pos < size) begin
          r.read_value = shadow_list[pos];
          r.status     = ST_OK;
        end
      end
      default: ;  // unused kind: no change, bad position
    endcase
    r.list_count = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  function automatic in_word_t make_word(op_e op, int unsigned pos,
                                         logic [VAL_W-1:0] v);
    in_word_t w;
    w.kind     = op;
    w.position = POS_W'(pos);
    w.value    = v;
    return w;
  endfunction

  // Extremes show up often, the rest is uniform over all 32 bits.
  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests against the current list, steered toward
  // list_target in size; a small share of noise with any kind and a position up to 256.
  function automatic in_word_t random_request();
    int unsigned size;
    int unsigned insert_pct;
    int unsigned roll;
    size = shadow_list.size();
    if ($urandom_range(99) < 8)
      return make_word(op_e'($urandom_range(3)), $urandom_range(256), random_value());
    insert_pct = (size < list_target) ? 60 : 20;
    roll       = $urandom_range(99);
    if (size == 0 || roll < insert_pct)
      return make_word(OP_INSERT, $urandom_range(size), random_value());
    if (roll < insert_pct + (100 - insert_pct) / 2)
      return make_word(OP_DELETE, $urandom_range(size - 1), random_value());
    return make_word(OP_READ, $urandom_range(size - 1), random_value());
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one word from a falling edge and holds it until a rising edge
  // sees push high and full low. Idle cycles carry junk on the data lines.
  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      push      <= 1'b0;
      in_word_i <= in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(predict_list_op(w));
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni || rx_stalled) begin
      pop <= 1'b0;
    end else begin
      pop <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long hold-off on pop, counted here so the sender keeps pushing meanwhile.
  always begin
    @(stall_kick);
    @(posedge clk_i);
    rx_stalled = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    rx_stalled = 1'b0;
  end

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", 64'(out_word_o), '0);
      end else begin
        next_expected = pending_results.pop_front();
        if (out_word_o.status !== next_expected.status)
          flag_mismatch("status", 64'(out_word_o.status), 64'(next_expected.status));
        if (out_word_o.read_value !== next_expected.read_value)
          flag_mismatch("read_value", 64'(out_word_o.read_value),
                        64'(next_expected.read_value));
        if (out_word_o.list_count !== next_expected.list_count)
          flag_mismatch("list_count", 64'(out_word_o.list_count),
                        64'(next_expected.list_count));
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty-list rejects, unused kind, extreme values, head and tail inserts,
  // head / middle / tail deletes, reads at and past the end, emptying the list.
  task automatic test_directed_edges();
    send_word(make_word(OP_READ,   0,   32'h1234_5678));
    send_word(make_word(OP_DELETE, 0,   32'h0));
    send_word(make_word(OP_INSERT, 1,   32'h1));
    send_word(make_word(OP_INSERT, 256, 32'hffff_ffff));
    send_word(make_word(OP_NOP,    0,   32'hdead_beef));
    send_word(make_word(OP_INSERT, 0,   32'h7fff_ffff));
    send_word(make_word(OP_INSERT, 1,   32'h8000_0000));
    send_word(make_word(OP_INSERT, 0,   32'h0));
    send_word(make_word(OP_INSERT, 3,   32'hffff_ffff));
    for (int p = 0; p <= 4; p++) send_word(make_word(OP_READ, p, 32'h0));
    send_word(make_word(OP_DELETE, 4,   32'h0));
    send_word(make_word(OP_NOP,    256, 32'hffff_ffff));
    send_word(make_word(OP_DELETE, 3,   32'h0));
    send_word(make_word(OP_DELETE, 1,   32'h0));
    send_word(make_word(OP_DELETE, 0,   32'h0));
    send_word(make_word(OP_READ,   0,   32'h0));
    send_word(make_word(OP_DELETE, 0,   32'h0));
    send_word(make_word(OP_INSERT, 0,   32'h5a5a_a5a5));
    send_word(make_word(OP_READ,   0,   32'h0));
    send_word(make_word(OP_DELETE, 0,   32'h0));
  endtask

  // Receiver holds off while short requests keep coming, so both queues fill
  // and full stalls the sender until pop resumes.
  task automatic test_receiver_stall();
    -> stall_kick;
    for (int i = 0; i < 24; i++) begin
      case (i % 3)
        0:       send_word(make_word(OP_INSERT, 0, random_value()));
        1:       send_word(make_word(OP_READ,   0, random_value()));
        default: send_word(make_word(OP_DELETE, 0, random_value()));
      endcase
    end
  endtask

  // Fill the pool, hit the full status at both ends, work at the last
  // position, then empty the list again.
  task automatic test_pool_full();
    int unsigned size;
    while (shadow_list.size() < CAPACITY_DEF) begin
      size = shadow_list.size();
      if ($urandom_range(15) == 0)
        send_word(make_word(OP_INSERT, $urandom_range(size), random_value()));
      else
        send_word(make_word(OP_INSERT, $urandom_range(size < 4 ? size : 4),
                            random_value()));
    end
    send_word(make_word(OP_INSERT, 256, random_value()));
    send_word(make_word(OP_INSERT, 0,   random_value()));
    send_word(make_word(OP_READ,   255, 32'h0));
    send_word(make_word(OP_READ,   256, 32'h0));
    send_word(make_word(OP_DELETE, 256, 32'h0));
    send_word(make_word(OP_DELETE, 255, 32'h0));
    send_word(make_word(OP_INSERT, 255, random_value()));
    send_word(make_word(OP_READ,   255, 32'h0));
    send_word(make_word(OP_INSERT, 128, random_value()));
    while (shadow_list.size() > 0) begin
      size = shadow_list.size();
      if ($urandom_range(15) == 0)
        send_word(make_word(OP_DELETE, $urandom_range(size - 1), 32'h0));
      else
        send_word(make_word(OP_DELETE, 0, 32'h0));
    end
    send_word(make_word(OP_READ, 0, 32'h0));
  endtask

  // Segments with their own target size: mostly short lists, one that grows
  // long, and one with no idle cycles on either side.
  task automatic test_random_ops();
    for (int seg = 0; seg < 9; seg++) begin
      steady_flow = (seg == 6);
      list_target = (seg == 8) ? CAPACITY_DEF : $urandom_range(0, 32);
      repeat (97) send_word(random_request());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_receiver_stall();
    test_pool_full();
    test_random_ops();
    wait_for_drain();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
